FILE: design/odo_pkg.sv
// ----------------------------------------------------------------------------
// odo_pkg
// shared types, constants and tables of the differential drive odometry unit
// ----------------------------------------------------------------------------
package odo_pkg;

    typedef struct packed {
        logic signed [15:0] ticks_left;
        logic signed [15:0] ticks_right;
        logic [23:0]        elapsed_us;
    } odo_in_t;

    typedef struct packed {
        logic signed [31:0] x_pos;
        logic signed [31:0] y_pos;
        logic signed [15:0] heading;
        logic signed [31:0] step_distance;
        logic signed [31:0] linear_speed;
        logic signed [31:0] angular_speed;
        logic signed [47:0] distance_sum;
        logic signed [47:0] left_tick_sum;
        logic signed [47:0] right_tick_sum;
    } odo_out_t;

    typedef enum logic [7:0] {
        CFG_LEFT_MM_PER_TICK = 8'd0,
        CFG_RIGHT_CORRECTION = 8'd1,
        CFG_WHEELBASE_MM     = 8'd2
    } odo_cfg_idx_t;

    typedef enum logic [1:0] {
        DIV_ANGLE = 2'd0,
        DIV_LIN   = 2'd1,
        DIV_ROT   = 2'd2
    } odo_div_sel_t;

    localparam int CORDIC_ITERS = 24;
    localparam int ITER_W       = 5;
    localparam int DIV_NW       = 60;   // dividend / quotient width
    localparam int DIV_DW       = 28;   // divisor width

    localparam logic signed [58:0] INV_TWO_PI_Q24  = 59'sd2670177;
    localparam logic signed [34:0] CORDIC_GAIN_Q30 = 35'sd652032874;
    localparam logic signed [59:0] US_PER_S        = 60'sd1000000;

    typedef struct packed {
        logic         ld_in;
        logic         ld_mul1;
        logic         ld_mul2;
        logic         ld_sum;
        logic         ld_num;
        logic         div_start;
        odo_div_sel_t div_sel;
        logic         ld_angle;
        logic         cord_step;
        logic [ITER_W-1:0] cord_idx;
        logic         ld_prod;
        logic         ld_pos;
        logic         ld_lin;
        logic         ld_rot;
        logic         ld_out;
    } odo_cmd_t;

    typedef struct packed {
        logic div_busy;
        logic div_done;
        logic us_zero;
    } odo_stat_t;

    // atan(2^-i) in 2^32-per-turn units
    function automatic logic [29:0] atan_turn(input logic [ITER_W-1:0] i);
        logic [29:0] r;
        unique case (i)
            5'd0:  r = 30'd536870912;
            5'd1:  r = 30'd316933406;
            5'd2:  r = 30'd167458907;
            5'd3:  r = 30'd85004756;
            5'd4:  r = 30'd42667331;
            5'd5:  r = 30'd21352417;
            5'd6:  r = 30'd10679838;
            5'd7:  r = 30'd5340245;
            5'd8:  r = 30'd2670163;
            5'd9:  r = 30'd1335087;
            5'd10: r = 30'd667544;
            5'd11: r = 30'd333772;
            5'd12: r = 30'd166886;
            5'd13: r = 30'd83443;
            5'd14: r = 30'd41722;
            5'd15: r = 30'd20861;
            5'd16: r = 30'd10430;
            5'd17: r = 30'd5215;
            5'd18: r = 30'd2608;
            5'd19: r = 30'd1304;
            5'd20: r = 30'd652;
            5'd21: r = 30'd326;
            5'd22: r = 30'd163;
            5'd23: r = 30'd81;
            default: r = 30'd0;
        endcase
        return r;
    endfunction

endpackage

FILE: design/odo_div.sv
// ----------------------------------------------------------------------------
// odo_div
// restoring unsigned divider, one quotient bit per cycle
// ----------------------------------------------------------------------------
module odo_div (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          start,
    input  logic [odo_pkg::DIV_NW-1:0]    dividend,
    input  logic [odo_pkg::DIV_DW-1:0]    divisor,
    output logic [odo_pkg::DIV_NW-1:0]    quotient,
    output logic                          busy,
    output logic                          done
);
    localparam int NW = odo_pkg::DIV_NW;
    localparam int DW = odo_pkg::DIV_DW;
    localparam int CW = $clog2(NW);

    logic [DW-1:0] rem_reg, rem_next;
    logic [NW-1:0] quo_reg, quo_next;
    logic [DW-1:0] dvs_reg;
    logic [CW-1:0] cnt_reg;
    logic          busy_reg, done_reg;
    logic [DW:0]   trial;
    logic [DW:0]   diff;

    always_comb begin
        trial    = {rem_reg, quo_reg[NW-1]};
        diff     = trial - {1'b0, dvs_reg};
        rem_next = trial[DW-1:0];
        quo_next = {quo_reg[NW-2:0], 1'b0};
        if (trial >= {1'b0, dvs_reg}) begin
            rem_next = diff[DW-1:0];
            quo_next = {quo_reg[NW-2:0], 1'b1};
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end else if (busy_reg) begin
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == CW'(NW - 1)) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            rem_reg <= '0;
            quo_reg <= dividend;
            dvs_reg <= divisor;
        end else if (busy_reg) begin
            rem_reg <= rem_next;
            quo_reg <= quo_next;
        end
    end

    assign quotient = quo_reg;
    assign busy     = busy_reg;
    assign done     = done_reg;
endmodule

FILE: design/odo_datapath.sv
// ----------------------------------------------------------------------------
// odo_datapath
// registers, multipliers, cordic rotator and divider of the odometry unit
// ----------------------------------------------------------------------------
module odo_datapath (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  odo_pkg::odo_cmd_t    cmd,
    output odo_pkg::odo_stat_t   stat,
    input  odo_pkg::odo_in_t     in_word,
    input  logic                 cfg_we,
    input  logic [7:0]           cfg_index,
    input  logic [23:0]          cfg_data,
    output odo_pkg::odo_out_t    out_word
);
    localparam int NW = odo_pkg::DIV_NW;

    // configuration
    logic [23:0] lm_reg;
    logic [16:0] rc_reg;
    logic [11:0] wb_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            lm_reg <= 24'd14364;
            rc_reg <= 17'd65536;
            wb_reg <= 12'd288;
        end else if (cfg_we) begin
            if (cfg_index == odo_pkg::CFG_LEFT_MM_PER_TICK) lm_reg <= cfg_data;
            if (cfg_index == odo_pkg::CFG_RIGHT_CORRECTION) rc_reg <= cfg_data[16:0];
            if (cfg_index == odo_pkg::CFG_WHEELBASE_MM)     wb_reg <= cfg_data[11:0];
        end
    end

    // item registers
    logic signed [15:0] tl_reg, tr_reg;
    logic [23:0]        us_reg;
    logic signed [40:0] pl_reg, trlm_reg;
    logic signed [32:0] dl_reg;
    logic signed [58:0] prr_reg;
    logic signed [31:0] step_reg;
    logic signed [35:0] diff_reg;
    logic signed [58:0] num_reg;
    logic signed [42:0] dth_reg;
    logic               flip_reg;
    logic signed [34:0] cx_reg, cy_reg;
    logic signed [32:0] cz_reg;
    logic signed [63:0] prx_reg, pry_reg;
    logic               spd_neg_reg;
    logic signed [31:0] lin_reg, rot_reg;

    // state
    logic [31:0] pos_x_reg, pos_y_reg;
    logic [15:0] pose_reg;
    logic [47:0] dist_reg, ltot_reg, rtot_reg;

    odo_pkg::odo_out_t out_reg;

    // wheel products
    logic signed [40:0] lm_s41, tl_s41, tr_s41, t_dl;
    logic signed [58:0] trlm_s59, rc_s59, t_dr, diff_s59;
    logic signed [34:0] dr_w;
    logic signed [35:0] sum_w, half_w, dl_s36, dr_s36;
    logic signed [31:0] step_w;

    always_comb begin
        lm_s41   = $signed({17'd0, lm_reg});
        tl_s41   = 41'(tl_reg);
        tr_s41   = 41'(tr_reg);
        trlm_s59 = 59'(trlm_reg);
        rc_s59   = $signed({42'd0, rc_reg});
        t_dl     = pl_reg + 41'sd128;
        t_dr     = prr_reg + 59'sd8388608;
        dr_w     = t_dr[58:24];
        dl_s36   = 36'(dl_reg);
        dr_s36   = 36'(dr_w);
        sum_w    = dl_s36 + dr_s36;
        half_w   = (sum_w + 36'sd1) >>> 1;
        if (half_w > 36'sd2147483647)       step_w = 32'sh7fffffff;
        else if (half_w < -36'sd2147483648) step_w = 32'sh80000000;
        else                                step_w = half_w[31:0];
        diff_s59 = 59'(diff_reg);
    end

    // divider operands
    logic [11:0]         wb_eff;
    logic [NW-1:0]       num_mag, ang_dividend, spd_mag, div_a;
    logic [27:0]         div_b;
    logic signed [38:0]  va;
    logic signed [59:0]  spd_v, spd_prod;
    logic                spd_neg;
    logic [NW-1:0]       quo;
    logic                div_busy_w, div_done_w, us_zero_w;

    always_comb begin
        wb_eff       = (wb_reg == 12'd0) ? 12'd1 : wb_reg;
        num_mag      = num_reg[58] ? NW'(-num_reg) : NW'(num_reg);
        ang_dividend = num_mag + (NW'(wb_eff) << 15);
        if (dth_reg > 43'sd137438953472)       va = 39'sd137438953472;
        else if (dth_reg < -43'sd137438953472) va = -39'sd137438953472;
        else                                   va = dth_reg[38:0];
        spd_v    = (cmd.div_sel == odo_pkg::DIV_LIN) ? 60'(step_reg) : 60'(va);
        spd_prod = spd_v * odo_pkg::US_PER_S;
        spd_neg  = spd_prod[59];
        spd_mag  = spd_neg ? NW'(-spd_prod) : NW'(spd_prod);
        if (cmd.div_sel == odo_pkg::DIV_ANGLE) begin
            div_a = ang_dividend;
            div_b = {wb_eff, 16'd0};
        end else begin
            div_a = spd_mag;
            div_b = {4'd0, us_reg};
        end
    end

    odo_div u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (cmd.div_start),
        .dividend (div_a),
        .divisor  (div_b),
        .quotient (quo),
        .busy     (div_busy_w),
        .done     (div_done_w)
    );

    // heading change and cordic setup
    logic signed [42:0] dth_w;
    logic [15:0]        mid_w;
    logic [31:0]        turn_w;
    logic               fold_w;
    logic signed [31:0] sat_spd;

    always_comb begin
        dth_w  = num_reg[58] ? -$signed(quo[42:0]) : $signed(quo[42:0]);
        mid_w  = pose_reg + dth_reg[16:1];
        turn_w = {mid_w, 16'd0};
        fold_w = turn_w[31] ^ turn_w[30];
        if (spd_neg_reg) begin
            sat_spd = (quo > NW'(64'd2147483648)) ? 32'sh80000000 : -$signed(quo[31:0]);
        end else begin
            sat_spd = (quo > NW'(64'd2147483647)) ? 32'sh7fffffff : $signed(quo[31:0]);
        end
    end

    // cordic iteration
    logic signed [34:0] xs, ys, c_w, s_w;
    logic signed [32:0] at;
    logic signed [63:0] step64, c64, s64, rx_t, ry_t;

    always_comb begin
        xs     = cx_reg >>> cmd.cord_idx;
        ys     = cy_reg >>> cmd.cord_idx;
        at     = $signed({3'd0, odo_pkg::atan_turn(cmd.cord_idx)});
        c_w    = flip_reg ? -cx_reg : cx_reg;
        s_w    = flip_reg ? -cy_reg : cy_reg;
        step64 = 64'(step_reg);
        c64    = 64'(c_w);
        s64    = 64'(s_w);
        rx_t   = prx_reg + 64'sd536870912;
        ry_t   = pry_reg + 64'sd536870912;
    end

    always_ff @(posedge aclk) begin
        if (cmd.ld_in) begin
            tl_reg <= in_word.ticks_left;
            tr_reg <= in_word.ticks_right;
            us_reg <= in_word.elapsed_us;
        end
        if (cmd.ld_mul1) begin
            pl_reg   <= tl_s41 * lm_s41;
            trlm_reg <= tr_s41 * lm_s41;
        end
        if (cmd.ld_mul2) begin
            dl_reg  <= t_dl[40:8];
            prr_reg <= trlm_s59 * rc_s59;
        end
        if (cmd.ld_sum) begin
            step_reg <= step_w;
            diff_reg <= dr_s36 - dl_s36;
        end
        if (cmd.ld_num) num_reg <= diff_s59 * odo_pkg::INV_TWO_PI_Q24;
        if (cmd.div_start) spd_neg_reg <= spd_neg;
        if (cmd.ld_angle) begin
            dth_reg <= dth_w;
        end
        // the cordic setup below loads whenever cord_step is low, from the dth_reg that ld_angle loaded
        if (cmd.cord_step) begin
            if (!cz_reg[32]) begin
                cx_reg <= cx_reg - ys;
                cy_reg <= cy_reg + xs;
                cz_reg <= cz_reg - at;
            end else begin
                cx_reg <= cx_reg + ys;
                cy_reg <= cy_reg - xs;
                cz_reg <= cz_reg + at;
            end
        end else begin
            cx_reg   <= odo_pkg::CORDIC_GAIN_Q30;
            cy_reg   <= '0;
            cz_reg   <= 33'($signed(fold_w ? (turn_w ^ 32'h80000000) : turn_w));
            flip_reg <= fold_w;
        end
        if (cmd.ld_prod) begin
            prx_reg <= step64 * c64;
            pry_reg <= step64 * s64;
        end
        if (cmd.ld_lin) lin_reg <= us_zero_w ? 32'sd0 : sat_spd;
        if (cmd.ld_rot) rot_reg <= us_zero_w ? 32'sd0 : sat_spd;
        if (cmd.ld_out) begin
            out_reg.x_pos          <= pos_x_reg;
            out_reg.y_pos          <= pos_y_reg;
            out_reg.heading        <= pose_reg;
            out_reg.step_distance  <= step_reg;
            out_reg.linear_speed   <= lin_reg;
            out_reg.angular_speed  <= rot_reg;
            out_reg.distance_sum   <= dist_reg;
            out_reg.left_tick_sum  <= ltot_reg;
            out_reg.right_tick_sum <= rtot_reg;
        end
    end

    // odometry state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pos_x_reg <= '0;
            pos_y_reg <= '0;
            pose_reg  <= '0;
            dist_reg  <= '0;
            ltot_reg  <= '0;
            rtot_reg  <= '0;
        end else begin
            if (cmd.ld_prod) pose_reg <= pose_reg + dth_reg[15:0];
            if (cmd.ld_pos) begin
                pos_x_reg <= pos_x_reg + rx_t[61:30];
                pos_y_reg <= pos_y_reg + ry_t[61:30];
                dist_reg  <= dist_reg + 48'(step_reg);
                ltot_reg  <= ltot_reg + 48'(tl_reg);
                rtot_reg  <= rtot_reg + 48'(tr_reg);
            end
        end
    end

    assign us_zero_w = (us_reg == 24'd0);
    assign stat      = '{div_busy: div_busy_w, div_done: div_done_w, us_zero: us_zero_w};
    assign out_word  = out_reg;
endmodule

FILE: design/odo_ctrl.sv
// ----------------------------------------------------------------------------
// odo_ctrl
// sequencer of the odometry unit, one item at a time
// ----------------------------------------------------------------------------
module odo_ctrl (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    output logic               m_valid,
    input  logic               m_ready,
    input  odo_pkg::odo_stat_t stat,
    output odo_pkg::odo_cmd_t  cmd
);
    typedef enum logic [15:0] {
        ST_IDLE  = 16'b0000_0000_0000_0001,
        ST_MUL1  = 16'b0000_0000_0000_0010,
        ST_MUL2  = 16'b0000_0000_0000_0100,
        ST_SUM   = 16'b0000_0000_0000_1000,
        ST_NUM   = 16'b0000_0000_0001_0000,
        ST_DIVA  = 16'b0000_0000_0010_0000,
        ST_WAITA = 16'b0000_0000_0100_0000,
        ST_SETUP = 16'b0000_0000_1000_0000,
        ST_CORD  = 16'b0000_0001_0000_0000,
        ST_PROD  = 16'b0000_0010_0000_0000,
        ST_POS   = 16'b0000_0100_0000_0000,
        ST_DIVL  = 16'b0000_1000_0000_0000,
        ST_WAITL = 16'b0001_0000_0000_0000,
        ST_DIVR  = 16'b0010_0000_0000_0000,
        ST_WAITR = 16'b0100_0000_0000_0000,
        ST_OUT   = 16'b1000_0000_0000_0000
    } odo_state_t;

    odo_state_t state_reg, state_next;
    logic [odo_pkg::ITER_W-1:0] it_reg, it_next;
    logic valid_reg, valid_next;

    always_comb begin
        state_next = state_reg;
        it_next    = it_reg;
        valid_next = valid_reg;
        cmd        = '0;
        cmd.div_sel  = odo_pkg::DIV_ANGLE;
        cmd.cord_idx = it_reg;
        if (valid_reg && m_ready) valid_next = 1'b0;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    cmd.ld_in  = 1'b1;
                    state_next = ST_MUL1;
                end
            end
            ST_MUL1: begin
                cmd.ld_mul1 = 1'b1;
                state_next  = ST_MUL2;
            end
            ST_MUL2: begin
                cmd.ld_mul2 = 1'b1;
                state_next  = ST_SUM;
            end
            ST_SUM: begin
                cmd.ld_sum = 1'b1;
                state_next = ST_NUM;
            end
            ST_NUM: begin
                cmd.ld_num = 1'b1;
                state_next = ST_DIVA;
            end
            ST_DIVA: begin
                cmd.div_start = 1'b1;
                state_next    = ST_WAITA;
            end
            ST_WAITA: begin
                if (stat.div_done) begin
                    cmd.ld_angle = 1'b1;
                    state_next   = ST_SETUP;
                end
            end
            ST_SETUP: begin
                it_next    = '0;
                state_next = ST_CORD;
            end
            ST_CORD: begin
                cmd.cord_step = 1'b1;
                it_next       = it_reg + 1'b1;
                if (it_reg == odo_pkg::ITER_W'(odo_pkg::CORDIC_ITERS - 1)) begin
                    state_next = ST_PROD;
                end
            end
            ST_PROD: begin
                cmd.cord_step = 1'b1;
                cmd.cord_idx  = '1;
                cmd.ld_prod   = 1'b1;
                state_next    = ST_POS;
            end
            ST_POS: begin
                cmd.cord_step = 1'b1;
                cmd.cord_idx  = '1;
                cmd.ld_pos    = 1'b1;
                if (stat.us_zero) begin
                    cmd.ld_lin = 1'b1;
                    cmd.ld_rot = 1'b1;
                    state_next = ST_OUT;
                end else begin
                    state_next = ST_DIVL;
                end
            end
            ST_DIVL: begin
                cmd.div_sel   = odo_pkg::DIV_LIN;
                cmd.div_start = 1'b1;
                state_next    = ST_WAITL;
            end
            ST_WAITL: begin
                if (stat.div_done) begin
                    cmd.ld_lin = 1'b1;
                    state_next = ST_DIVR;
                end
            end
            ST_DIVR: begin
                cmd.div_sel   = odo_pkg::DIV_ROT;
                cmd.div_start = 1'b1;
                state_next    = ST_WAITR;
            end
            ST_WAITR: begin
                if (stat.div_done) begin
                    cmd.ld_rot = 1'b1;
                    state_next = ST_OUT;
                end
            end
            ST_OUT: begin
                if (!valid_reg || m_ready) begin
                    cmd.ld_out = 1'b1;
                    valid_next = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            it_reg    <= '0;
            valid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            it_reg    <= it_next;
            valid_reg <= valid_next;
        end
    end

    assign s_ready = (state_reg == ST_IDLE);
    assign m_valid = valid_reg;
endmodule

FILE: design/differential_drive_odometry_unit.sv
// ----------------------------------------------------------------------------
// differential_drive_odometry_unit
// midpoint-heading differential drive odometry in fixed point
// ----------------------------------------------------------------------------
// one word carries left and right encoder ticks and the period in us; the
// unit returns one result word with x, y (1/256 mm), heading (65536 per turn),
// the step, both speeds and the running totals. items are worked one at a
// time. the shared one-bit-per-cycle divider works out the heading change
// and, for a word with a nonzero period, each speed; every word also runs
// the 24 cordic iterations. a finished word waits in the output register
// while the next input word is taken. configuration writes are taken every
// cycle and belong between words.
module differential_drive_odometry_unit (
    input  logic              aclk,
    input  logic              aresetn,
    // input words
    input  logic              s_valid,
    output logic              s_ready,
    input  odo_pkg::odo_in_t  s_data,
    // result words
    output logic              m_valid,
    input  logic              m_ready,
    output odo_pkg::odo_out_t m_data,
    // register writes
    input  logic              cfg_valid,
    output logic              cfg_ready,
    input  logic [7:0]        cfg_index,
    input  logic [23:0]       cfg_data
);
    odo_pkg::odo_cmd_t  cmd;
    odo_pkg::odo_stat_t stat;

    // registers always writable
    assign cfg_ready = 1'b1;

    // sequencer
    odo_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .stat    (stat),
        .cmd     (cmd)
    );

    // arithmetic and state
    odo_datapath u_dp (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cmd       (cmd),
        .stat      (stat),
        .in_word   (s_data),
        .cfg_we    (cfg_valid && cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .out_word  (m_data)
    );

    // one word in flight: after a take the input stays closed
    a_one_item: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready)
        else $error("input taken while a word is in flight");

    // divider never restarted while running
    a_div_start: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.div_start |-> !stat.div_busy)
        else $error("divider restarted while busy");

    // output register not overwritten while a word waits
    a_no_overwrite: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.ld_out |-> (!m_valid || m_ready))
        else $error("result word overwritten");
endmodule
